// File: src/temp_sample_smooth_classify_assert.svh
// ----------------------------------------------------------------------------
// temp_sample_smooth_classify assertion macros
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TEMP_SAMPLE_SMOOTH_CLASSIFY_ASSERT_SVH
`define TEMP_SAMPLE_SMOOTH_CLASSIFY_ASSERT_SVH

`ifndef SYNTHESIS
`define TSSC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TSSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TSSC_ASSERT_SAME(label, clk, rst, ante, cons)
`define TSSC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: src/tssc_pkg.sv
// ----------------------------------------------------------------------------
// tssc_pkg
// Shared types, constants and the code range table of the temperature block.
// ----------------------------------------------------------------------------
package tssc_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned TEMP_W = 8;
  localparam int unsigned LED_W = 3;
  localparam int unsigned CFG_INDEX_W = 3;

  // Exponential average: new = (50 * old + 14 * sample) >> 6.
  localparam int unsigned AVG_OLD_WEIGHT = 50;
  localparam int unsigned AVG_NEW_WEIGHT = 14;
  localparam int unsigned AVG_SHIFT = 6;
  localparam int unsigned ACC_W = SAMPLE_W + AVG_SHIFT;

  localparam int unsigned TABLE_SIZE = 16;
  localparam int unsigned TABLE_IDX_W = $clog2(TABLE_SIZE);
  localparam int unsigned DEFAULT_RANGE_COUNT = 11;
  localparam int unsigned DEFAULT_QUEUE_DEPTH = 2;

  localparam logic signed [TEMP_W-1:0] TEMP_LOW = -8'sd100;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 8'sd100;

  localparam logic signed [TEMP_W-1:0] RESET_BASE_TEMP = 8'sd18;
  localparam logic signed [TEMP_W-1:0] RESET_LED_LIMIT_A = 8'sd21;
  localparam logic signed [TEMP_W-1:0] RESET_LED_LIMIT_B = 8'sd23;
  localparam logic signed [TEMP_W-1:0] RESET_LED_LIMIT_C = 8'sd26;
  localparam logic signed [TEMP_W-1:0] RESET_LED_LIMIT_D = 8'sd27;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BASE_TEMP   = 3'd0,
    REG_LED_LIMIT_A = 3'd1,
    REG_LED_LIMIT_B = 3'd2,
    REG_LED_LIMIT_C = 3'd3,
    REG_LED_LIMIT_D = 3'd4
  } reg_index_t;

  typedef enum logic [LED_W-1:0] {
    LED_0 = 3'd0,
    LED_1 = 3'd1,
    LED_2 = 3'd2,
    LED_3 = 3'd3,
    LED_4 = 3'd4
  } led_t;

  // Inclusive code ranges. Unused entries have low above high and never match.
  localparam logic [SAMPLE_W-1:0] RANGE_LO [TABLE_SIZE] = '{
    10'd262, 10'd266, 10'd269, 10'd273, 10'd277, 10'd281, 10'd285, 10'd289,
    10'd293, 10'd296, 10'd300, 10'd1,   10'd1,   10'd1,   10'd1,   10'd1
  };
  localparam logic [SAMPLE_W-1:0] RANGE_HI [TABLE_SIZE] = '{
    10'd265, 10'd269, 10'd273, 10'd277, 10'd281, 10'd284, 10'd288, 10'd292,
    10'd296, 10'd300, 10'd304, 10'd0,   10'd0,   10'd0,   10'd0,   10'd0
  };

  typedef struct packed {
    logic                   write;
    logic [CFG_INDEX_W-1:0] index;
    logic [TEMP_W-1:0]      data;
  } cfg_write_t;

  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] average;
  } avg_beat_t;

endpackage

// File: src/tssc_fifo.sv
// ----------------------------------------------------------------------------
// tssc_fifo
// Small register queue between the averaging front and the classifying back.
// ----------------------------------------------------------------------------
module tssc_fifo #(
  parameter int unsigned DEPTH = tssc_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int unsigned WIDTH = tssc_pkg::SAMPLE_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: src/tssc_front.sv
// ----------------------------------------------------------------------------
// tssc_front
// Accepts converter samples and keeps the exponential average.
// ----------------------------------------------------------------------------
module tssc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          full,
  input  logic [tssc_pkg::SAMPLE_W-1:0] sample,
  output tssc_pkg::avg_beat_t           beat
);

  logic [tssc_pkg::SAMPLE_W-1:0] average;
  logic [tssc_pkg::SAMPLE_W-1:0] average_next;
  logic                          seeded;
  logic [tssc_pkg::ACC_W-1:0]    acc;
  logic                          take;

  assign take = push && !full;

  // The sum of the two weights is 64, so the accumulator never exceeds 16 bits.
  assign acc = tssc_pkg::ACC_W'(tssc_pkg::AVG_OLD_WEIGHT) * tssc_pkg::ACC_W'(average)
             + tssc_pkg::ACC_W'(tssc_pkg::AVG_NEW_WEIGHT) * tssc_pkg::ACC_W'(sample);

  // The first sample after reset loads the average unchanged.
  assign average_next = seeded ? acc[tssc_pkg::ACC_W-1:tssc_pkg::AVG_SHIFT] : sample;

  assign beat.valid   = take;
  assign beat.average = average_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      average <= '0;
      seeded  <= 1'b0;
    end else if (take) begin
      average <= average_next;
      seeded  <= 1'b1;
    end
  end

endmodule

// File: src/tssc_back.sv
// ----------------------------------------------------------------------------
// tssc_back
// Maps an averaged code to degrees and an LED index, and holds the result.
// ----------------------------------------------------------------------------
module tssc_back #(
  parameter int unsigned RANGE_COUNT = tssc_pkg::DEFAULT_RANGE_COUNT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tssc_pkg::cfg_write_t               cfg,
  input  logic                               mid_empty,
  input  logic [tssc_pkg::SAMPLE_W-1:0]      mid_data,
  output logic                               mid_pop,
  input  logic                               pop,
  output logic                               empty,
  output logic [tssc_pkg::SAMPLE_W-1:0]      smoothed,
  output logic signed [tssc_pkg::TEMP_W-1:0] celsius,
  output logic [tssc_pkg::LED_W-1:0]         led_select
);

  logic signed [tssc_pkg::TEMP_W-1:0] base_temp;
  logic signed [tssc_pkg::TEMP_W-1:0] led_limit_a;
  logic signed [tssc_pkg::TEMP_W-1:0] led_limit_b;
  logic signed [tssc_pkg::TEMP_W-1:0] led_limit_c;
  logic signed [tssc_pkg::TEMP_W-1:0] led_limit_d;

  logic                               out_valid;
  logic                               hit;
  logic [tssc_pkg::TABLE_IDX_W-1:0]   hit_idx;
  logic signed [tssc_pkg::TEMP_W:0]   temp_sum;
  logic signed [tssc_pkg::TEMP_W-1:0] temp_next;
  logic [tssc_pkg::LED_W-1:0]         led_next;

  assign empty   = !out_valid;
  assign mid_pop = !mid_empty && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_temp   <= tssc_pkg::RESET_BASE_TEMP;
      led_limit_a <= tssc_pkg::RESET_LED_LIMIT_A;
      led_limit_b <= tssc_pkg::RESET_LED_LIMIT_B;
      led_limit_c <= tssc_pkg::RESET_LED_LIMIT_C;
      led_limit_d <= tssc_pkg::RESET_LED_LIMIT_D;
    end else if (cfg.write) begin
      case (cfg.index)
        tssc_pkg::REG_BASE_TEMP:   base_temp   <= cfg.data;
        tssc_pkg::REG_LED_LIMIT_A: led_limit_a <= cfg.data;
        tssc_pkg::REG_LED_LIMIT_B: led_limit_b <= cfg.data;
        tssc_pkg::REG_LED_LIMIT_C: led_limit_c <= cfg.data;
        tssc_pkg::REG_LED_LIMIT_D: led_limit_d <= cfg.data;
        default: ;
      endcase
    end
  end

  // First matching range wins; ranges past RANGE_COUNT are not considered.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < tssc_pkg::TABLE_SIZE; i++) begin
      if (i < RANGE_COUNT && !hit && mid_data >= tssc_pkg::RANGE_LO[i]
          && mid_data <= tssc_pkg::RANGE_HI[i]) begin
        hit     = 1'b1;
        hit_idx = tssc_pkg::TABLE_IDX_W'(i);
      end
    end
  end

  assign temp_sum = {base_temp[tssc_pkg::TEMP_W-1], base_temp}
                  + $signed({{(tssc_pkg::TEMP_W + 1 - tssc_pkg::TABLE_IDX_W){1'b0}}, hit_idx});

  always_comb begin
    if (mid_data < tssc_pkg::RANGE_LO[0]) begin
      temp_next = tssc_pkg::TEMP_LOW;
    end else if (!hit) begin
      temp_next = tssc_pkg::TEMP_HIGH;
    end else if (temp_sum < 9'(tssc_pkg::TEMP_LOW)) begin
      temp_next = tssc_pkg::TEMP_LOW;
    end else if (temp_sum > 9'(tssc_pkg::TEMP_HIGH)) begin
      temp_next = tssc_pkg::TEMP_HIGH;
    end else begin
      temp_next = temp_sum[tssc_pkg::TEMP_W-1:0];
    end
  end

  always_comb begin
    if (temp_next < led_limit_a) begin
      led_next = tssc_pkg::LED_0;
    end else if (temp_next < led_limit_b) begin
      led_next = tssc_pkg::LED_1;
    end else if (temp_next < led_limit_c) begin
      led_next = tssc_pkg::LED_2;
    end else if (temp_next < led_limit_d) begin
      led_next = tssc_pkg::LED_3;
    end else begin
      led_next = tssc_pkg::LED_4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mid_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      smoothed   <= mid_data;
      celsius    <= temp_next;
      led_select <= led_next;
    end
  end

endmodule

// File: src/temp_sample_smooth_classify.sv
// ----------------------------------------------------------------------------
// temp_sample_smooth_classify
// Smooths converter samples and classifies them into degrees and an LED.
// ----------------------------------------------------------------------------
//   channel   direction  handshake               fields
//   sample    in         push / full             sample
//   result    out        pop / empty             smoothed, celsius, led_select
//   config    in         cfg_write (no wait)     cfg_index, cfg_data
//
// One sample is taken per cycle while full is low; its average is written into the
// queue and then registered in the output register. The averaging recurrence closes in the front register.
// Reset is synchronous; the pointers, flags and config registers return to their default values.
// The queue of QUEUE_DEPTH entries absorbs a stalled output; full rises when
// it holds QUEUE_DEPTH averages.
// ----------------------------------------------------------------------------
`include "temp_sample_smooth_classify_assert.svh"

module temp_sample_smooth_classify #(
  parameter int unsigned RANGE_COUNT = tssc_pkg::DEFAULT_RANGE_COUNT,
  parameter int unsigned QUEUE_DEPTH = tssc_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [tssc_pkg::SAMPLE_W-1:0]        sample,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [tssc_pkg::SAMPLE_W-1:0]        smoothed,
  output logic signed [tssc_pkg::TEMP_W-1:0]   celsius,
  output logic [tssc_pkg::LED_W-1:0]           led_select,
  input  logic                                 cfg_write,
  input  logic [tssc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tssc_pkg::TEMP_W-1:0]          cfg_data
);

  tssc_pkg::avg_beat_t           beat;
  tssc_pkg::cfg_write_t          cfg;
  logic                          mid_empty;
  logic                          mid_pop;
  logic [tssc_pkg::SAMPLE_W-1:0] mid_data;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  tssc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .sample (sample),
    .beat   (beat)
  );

  tssc_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (tssc_pkg::SAMPLE_W)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (beat.valid),
    .wr_data (beat.average),
    .full    (full),
    .rd_en   (mid_pop),
    .rd_data (mid_data),
    .empty   (mid_empty)
  );

  tssc_back #(
    .RANGE_COUNT (RANGE_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .mid_empty  (mid_empty),
    .mid_data   (mid_data),
    .mid_pop    (mid_pop),
    .pop        (pop),
    .empty      (empty),
    .smoothed   (smoothed),
    .celsius    (celsius),
    .led_select (led_select)
  );

  // A queued average always reaches the output register when it is free.
  `TSSC_ASSERT_NEXT(a_mid_to_out, clk, rst, !mid_empty && (empty || pop), !empty)
  // Popping the last result with nothing queued leaves the output empty.
  `TSSC_ASSERT_NEXT(a_drain, clk, rst, pop && !empty && mid_empty, empty)
  // The degrees stay inside the saturation limits.
  `TSSC_ASSERT_SAME(a_temp_range, clk, rst, !empty,
                    celsius >= tssc_pkg::TEMP_LOW && celsius <= tssc_pkg::TEMP_HIGH)

endmodule

// File: tb/temp_sample_smooth_classify_checker.sv
// ----------------------------------------------------------------------------
// temp_sample_smooth_classify_checker
// Watches the sample, result and register ports, predicts every reading and
// compares each popped result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module temp_sample_smooth_classify_checker #(
  parameter int unsigned RANGE_COUNT = tssc_pkg::DEFAULT_RANGE_COUNT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  logic                               full,
  input  logic [tssc_pkg::SAMPLE_W-1:0]      sample,
  input  logic                               empty,
  input  logic                               pop,
  input  logic [tssc_pkg::SAMPLE_W-1:0]      smoothed,
  input  logic signed [tssc_pkg::TEMP_W-1:0] celsius,
  input  logic [tssc_pkg::LED_W-1:0]         led_select,
  input  logic                               cfg_write,
  input  logic [tssc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tssc_pkg::TEMP_W-1:0]        cfg_data,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 checked,
  output int                                 full_stalls
);
  timeunit 1ns;
  timeprecision 1ps;

  import tssc_pkg::*;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned OLD_WEIGHT = 50;
  localparam int unsigned NEW_WEIGHT = 14;
  localparam int unsigned WEIGHT_SHIFT = 6;
  localparam int COLD_LIMIT = -100;
  localparam int HOT_LIMIT = 100;
  localparam int MAX_REPORTS = 10;

  // Inclusive code windows; the tail entries are empty and never match.
  localparam int unsigned CODE_LO [ENTRIES] = '{
    262, 266, 269, 273, 277, 281, 285, 289, 293, 296, 300, 1, 1, 1, 1, 1
  };
  localparam int unsigned CODE_HI [ENTRIES] = '{
    265, 269, 273, 277, 281, 284, 288, 292, 296, 300, 304, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic [SAMPLE_W-1:0]      smoothed;
    logic signed [TEMP_W-1:0] celsius;
    led_t                     led;
  } reading_t;

  reading_t             readings_due [$];
  logic [SAMPLE_W-1:0]  avg_code;
  bit                   avg_seeded;
  logic signed [TEMP_W-1:0] base_temp;
  logic signed [TEMP_W-1:0] limit_a;
  logic signed [TEMP_W-1:0] limit_b;
  logic signed [TEMP_W-1:0] limit_c;
  logic signed [TEMP_W-1:0] limit_d;

  function automatic logic signed [TEMP_W-1:0] code_to_celsius(logic [SAMPLE_W-1:0] code);
    int t;
    if (code < CODE_LO[0]) return TEMP_W'(COLD_LIMIT);
    for (int i = 0; i < int'(RANGE_COUNT) && i < int'(ENTRIES); i++) begin
      if (code >= CODE_LO[i] && code <= CODE_HI[i]) begin
        t = int'(base_temp) + i;
        if (t < COLD_LIMIT) t = COLD_LIMIT;
        if (t > HOT_LIMIT) t = HOT_LIMIT;
        return t[TEMP_W-1:0];
      end
    end
    return TEMP_W'(HOT_LIMIT);
  endfunction

  // Advances the running average by one sample and classifies the new value.
  function automatic reading_t smooth_and_classify(logic [SAMPLE_W-1:0] s);
    reading_t    r;
    int unsigned acc;
    int          t;
    if (!avg_seeded) begin
      avg_code = s;
      avg_seeded = 1'b1;
    end else begin
      acc = OLD_WEIGHT * avg_code + NEW_WEIGHT * s;
      acc = acc >> WEIGHT_SHIFT;
      avg_code = acc[SAMPLE_W-1:0];
    end
    r.smoothed = avg_code;
    r.celsius = code_to_celsius(avg_code);
    t = int'(r.celsius);
    if (t < int'(limit_a)) r.led = LED_0;
    else if (t < int'(limit_b)) r.led = LED_1;
    else if (t < int'(limit_c)) r.led = LED_2;
    else if (t < int'(limit_d)) r.led = LED_3;
    else r.led = LED_4;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reading_t want;
    if (rst) begin
      avg_code = '0;
      avg_seeded = 1'b0;
      base_temp = 8'sd18;
      limit_a = 8'sd21;
      limit_b = 8'sd23;
      limit_c = 8'sd26;
      limit_d = 8'sd27;
      readings_due.delete();
      pending <= 0;
      fail_count <= 0;
      checked <= 0;
      full_stalls <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_BASE_TEMP:   base_temp = cfg_data;
          REG_LED_LIMIT_A: limit_a = cfg_data;
          REG_LED_LIMIT_B: limit_b = cfg_data;
          REG_LED_LIMIT_C: limit_c = cfg_data;
          REG_LED_LIMIT_D: limit_d = cfg_data;
          default: ;
        endcase
      end
      // The result side is handled first so that a beat can never be matched
      // against a sample taken at the same edge.
      if (pop && !empty) begin
        if (readings_due.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: result beat with nothing outstanding: smoothed=%0d celsius=%0d led=%0d",
                     $time, smoothed, celsius, led_select);
          fail_count <= fail_count + 1;
        end else begin
          want = readings_due.pop_front();
          if (smoothed !== want.smoothed || celsius !== want.celsius ||
              led_select !== want.led) begin
            if (fail_count < MAX_REPORTS)
              $display("%0t: mismatch: expected smoothed=%0d celsius=%0d led=%0d,",
                       $time, want.smoothed, $signed(want.celsius), want.led,
                       " got smoothed=%0d celsius=%0d led=%0d",
                       smoothed, celsius, led_select);
            fail_count <= fail_count + 1;
          end
          checked <= checked + 1;
        end
      end
      if (push && !full) readings_due.push_back(smooth_and_classify(sample));
      if (push && full) full_stalls <= full_stalls + 1;
      pending <= readings_due.size();
    end
  end

endmodule

// File: tb/temp_sample_smooth_classify_tb.sv
// ----------------------------------------------------------------------------
// temp_sample_smooth_classify_tb
// Feeds converter samples through the smoothing classifier under random gaps,
// receiver stalls and a series of register settings; the checker beside the
// block predicts every reading and this module reports the verdict.
// ----------------------------------------------------------------------------
module temp_sample_smooth_classify_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tssc_pkg::*;

  localparam int unsigned RANGE_COUNT = DEFAULT_RANGE_COUNT;
  localparam int IDLE_PCT = 27;
  localparam int RANDOM_ITEMS = 1500;
  localparam int PHASE_ITEMS = 250;
  localparam int HOLD_AT_ITEM = 300;
  localparam int HOLD_CYCLES = 200;
  localparam int STEADY_FIRST = 600;
  localparam int STEADY_LAST = 800;
  localparam int TAIL_CYCLES = 10;
  localparam int NUM_REGS = int'(REG_LED_LIMIT_D) + 1;
  localparam int CFG_INDEX_MAX = (1 << CFG_INDEX_W) - 1;
  localparam int DIRECTED_COUNT = 16;
  localparam logic [SAMPLE_W-1:0] DIRECTED [DIRECTED_COUNT] = '{
    10'd283, 10'd1023, 10'd1023, 10'd0, 10'd0, 10'h155, 10'h2AA, 10'd262,
    10'd262, 10'd262, 10'd262, 10'd269, 10'd269, 10'd304, 10'd304, 10'd310
  };

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      push = 1'b0;
  logic                      full;
  logic [SAMPLE_W-1:0]       sample = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic [SAMPLE_W-1:0]       smoothed;
  logic signed [TEMP_W-1:0]  celsius;
  logic [LED_W-1:0]          led_select;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [TEMP_W-1:0]         cfg_data = '0;

  int fail_count;
  int pending;
  int checked;
  int full_stalls;
  int samples_sent = 0;
  int settings_used = 1;
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  temp_sample_smooth_classify #(.RANGE_COUNT(RANGE_COUNT)) dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .sample(sample),
    .empty(empty), .pop(pop), .smoothed(smoothed), .celsius(celsius),
    .led_select(led_select), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  temp_sample_smooth_classify_checker #(.RANGE_COUNT(RANGE_COUNT)) u_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .sample(sample),
    .empty(empty), .pop(pop), .smoothed(smoothed), .celsius(celsius),
    .led_select(led_select), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending),
    .checked(checked), .full_stalls(full_stalls)
  );

  // Offers one sample and returns at the edge where the beat is taken.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    sample <= s;
    do @(posedge clk); while (full);
    samples_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Writes all five registers, then one random unused index with junk data.
  task automatic apply_settings(input logic [TEMP_W-1:0] base, a, b, c, d);
    reg_index_t          regs [NUM_REGS];
    logic [TEMP_W-1:0]   vals [NUM_REGS];
    regs = '{REG_BASE_TEMP, REG_LED_LIMIT_A, REG_LED_LIMIT_B, REG_LED_LIMIT_C,
             REG_LED_LIMIT_D};
    vals = '{base, a, b, c, d};
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_index <= CFG_INDEX_W'($urandom_range(NUM_REGS, CFG_INDEX_MAX));
    cfg_data <= TEMP_W'($urandom_range(0, 255));
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Mostly a threshold a little above the base so that every LED shows up.
  function automatic logic [TEMP_W-1:0] pick_limit(input int base);
    if ($urandom_range(0, 3) == 0) return TEMP_W'($urandom_range(0, 255));
    return TEMP_W'(base + int'($urandom_range(0, 12)));
  endfunction

  // Result side: random pops, one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        pop <= !rst && (steady || $urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    logic [SAMPLE_W-1:0] s;
    int                  roll;
    int                  base;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: seeding sample, code extremes, table edges and overlap.
    foreach (DIRECTED[i]) send_sample(DIRECTED[i]);

    // Register extremes, then saturation of the degrees and unordered limits.
    wait_drained();
    apply_settings(8'sd100, -8'sd100, -8'sd50, 8'sd50, 8'sd100);
    send_sample(10'd290);
    send_sample(10'd304);
    send_sample(10'd1023);
    wait_drained();
    apply_settings(-8'sd128, 8'sd127, -8'sd128, 8'sd0, 8'sd5);
    send_sample(10'd262);
    send_sample(10'd262);
    send_sample(10'd0);
    wait_drained();
    apply_settings(8'sd127, 8'sd127, 8'sd127, 8'sd127, -8'sd128);
    send_sample(10'd280);
    send_sample(10'd280);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        wait_drained();
        if ($urandom_range(0, 3) == 0) base = int'($urandom_range(0, 255)) - 128;
        else base = int'($urandom_range(14, 22));
        apply_settings(TEMP_W'(base), pick_limit(base), pick_limit(base),
                       pick_limit(base), pick_limit(base));
      end
      if (n == HOLD_AT_ITEM) hold_req = 1'b1;
      steady = (n >= STEADY_FIRST && n <= STEADY_LAST);
      roll = $urandom_range(0, 99);
      if (roll < 70) s = SAMPLE_W'($urandom_range(250, 320));
      else if (roll < 88) s = SAMPLE_W'($urandom_range(0, 1023));
      else s = $urandom_range(0, 1) ? '1 : '0;
      send_sample(s);
    end
    steady = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d samples under %0d register settings, %0d results checked.",
             samples_sent, settings_used, checked);
    $display("Input was held off by full on %0d cycles; %0d mismatches seen.",
             full_stalls, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out waiting for the block.");
    $display("Test completed with failures");
    $finish;
  end

endmodule
